// ===== rtl/core/ffua_pkg.sv =====
package ffua_pkg;

    localparam int CFG_W    = 11;
    localparam int OP_W     = 2;
    localparam int OWNER_W  = 16;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;
    localparam int ADDR_W   = 3;

    // Register index is paddr[2]: block_units at 0x0, units_in_use at 0x4.
    localparam logic CFG_BLOCK_UNITS  = 1'b0;
    localparam logic CFG_UNITS_IN_USE = 1'b1;

    localparam logic [CFG_W-1:0] BLOCK_UNITS_RST  = 11'd1;
    localparam logic [CFG_W-1:0] UNITS_IN_USE_RST = 11'd1024;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_SCAN  = 2'd2,
        S_FILL  = 2'd3
    } t_state;

    typedef struct packed {
        logic init;
        logic valid;
    } t_scan_cmd;

    typedef struct packed {
        logic hit;
        logic found;
        logic match;
    } t_scan_res;

endpackage

// ===== rtl/core/ffua_ram.sv =====
module ffua_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ffua_scan.sv =====
// Per-unit evaluator: one owner word per cycle, tracking residency, the
// current free run, the first fitting run and the number of owner matches.
module ffua_scan #(
    parameter int OWNER_BITS = 16,
    parameter int CW         = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffua_pkg::t_scan_cmd           i_cmd,
    input  logic [OWNER_BITS-1:0]         i_owner,
    input  logic [OWNER_BITS-1:0]         i_data,
    input  logic [CW-1:0]                 i_idx,
    input  logic [ffua_pkg::CFG_W-1:0]    i_block,
    output ffua_pkg::t_scan_res           o_res,
    output logic [CW-1:0]                 o_start,
    output logic [ffua_pkg::CFG_W-1:0]    o_cnt
);

    logic                       r_hit;
    logic                       r_found;
    logic [ffua_pkg::CFG_W-1:0] r_run;
    logic [ffua_pkg::CFG_W-1:0] r_cnt;
    logic [CW-1:0]              r_start;

    logic                       w_free;
    logic                       w_match;
    logic                       w_fit;
    logic [ffua_pkg::CFG_W-1:0] n_run;
    logic [CW-1:0]              n_start;

    always_comb begin
        w_free  = (i_data == '0);
        w_match = i_cmd.valid && (i_data == i_owner);
        n_run   = w_free ? r_run + 1'b1 : '0;
        w_fit   = i_cmd.valid && !r_found && w_free && (n_run == i_block);
        n_start = CW'(32'(i_idx) + 32'd1 - 32'(i_block));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_found <= 1'b0;
            r_run   <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.init) begin
            r_hit   <= 1'b0;
            r_found <= 1'b0;
            r_run   <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.valid) begin
            r_run <= n_run;
            if (w_match) begin
                r_hit <= 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_fit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fit) begin
            r_start <= n_start;
        end
    end

    assign o_res.hit   = r_hit;
    assign o_res.found = r_found;
    assign o_res.match = w_match;
    assign o_start     = r_start;
    assign o_cnt       = r_cnt;

endmodule

// ===== rtl/core/ffua_ctrl.sv =====
// Sequencer: clearing pass, map scan, run fill, counters and result words.
module ffua_ctrl #(
    parameter int MAP_DEPTH  = 1024,
    parameter int OWNER_BITS = 16,
    parameter int AW         = 10,
    parameter int CW         = 11
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ffua_pkg::OP_W-1:0]       i_operation,
    input  logic [ffua_pkg::OWNER_W-1:0]    i_owner_id,
    input  logic [ffua_pkg::CFG_W-1:0]      i_block,
    input  logic [CW-1:0]                   i_managed,
    input  logic                            i_reinit,
    output ffua_pkg::t_scan_cmd             o_scan_cmd,
    input  ffua_pkg::t_scan_res             i_scan_res,
    input  logic [CW-1:0]                   i_scan_start,
    input  logic [ffua_pkg::CFG_W-1:0]      i_scan_cnt,
    output logic [OWNER_BITS-1:0]           o_owner,
    output logic [CW-1:0]                   o_chk_idx,
    output logic                            o_we,
    output logic [AW-1:0]                   o_waddr,
    output logic [OWNER_BITS-1:0]           o_wdata,
    output logic [AW-1:0]                   o_raddr,
    output logic                            o_done,
    output logic [ffua_pkg::STATUS_W-1:0]   o_status,
    output logic [ffua_pkg::START_W-1:0]    o_start_unit,
    output logic [ffua_pkg::CFG_W-1:0]      o_free_unit_count,
    output logic [ffua_pkg::CFG_W-1:0]      o_resident_owners
);

    ffua_pkg::t_state r_state, n_state;
    ffua_pkg::t_op    r_op, n_op;

    logic [CW-1:0]                  r_addr, n_addr;
    logic [CW-1:0]                  r_chk, n_chk;
    logic                           r_dv, n_dv;
    logic [OWNER_BITS-1:0]          r_owner, n_owner;
    logic [ffua_pkg::CFG_W-1:0]     r_left, n_left;
    logic [ffua_pkg::CFG_W-1:0]     r_free, n_free;
    logic [ffua_pkg::CFG_W-1:0]     r_owners, n_owners;
    logic                           r_done, n_done;
    logic [ffua_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [ffua_pkg::START_W-1:0]   r_start_unit, n_start_unit;

    logic [OWNER_BITS-1:0] w_owner_in;
    logic                  w_issue;

    always_comb begin
        w_owner_in   = OWNER_BITS'(i_owner_id);
        w_issue      = (r_addr != i_managed);
        n_state      = r_state;
        n_op         = r_op;
        n_addr       = r_addr;
        n_chk        = r_chk;
        n_dv         = 1'b0;
        n_owner      = r_owner;
        n_left       = r_left;
        n_free       = r_free;
        n_owners     = r_owners;
        n_done       = 1'b0;
        n_status     = r_status;
        n_start_unit = r_start_unit;
        o_scan_cmd   = '0;
        o_we         = 1'b0;
        o_waddr      = r_chk[AW-1:0];
        o_wdata      = '0;
        o_raddr      = r_addr[AW-1:0];

        case (r_state)
            ffua_pkg::S_CLEAR: begin
                o_we     = 1'b1;
                o_waddr  = r_addr[AW-1:0];
                n_free   = ffua_pkg::CFG_W'(i_managed);
                n_owners = '0;
                if (r_addr == CW'(MAP_DEPTH - 1)) begin
                    n_state = ffua_pkg::S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ffua_pkg::S_IDLE: begin
                if (start) begin
                    n_op            = ffua_pkg::t_op'(i_operation);
                    n_owner         = w_owner_in;
                    n_addr          = '0;
                    o_scan_cmd.init = 1'b1;
                    n_start_unit    = '0;
                    if (ffua_pkg::t_op'(i_operation) == ffua_pkg::OP_NONE) begin
                        n_done   = 1'b1;
                        n_status = ffua_pkg::ST_OK;
                    end else if (w_owner_in == '0) begin
                        n_done   = 1'b1;
                        n_status = ffua_pkg::ST_REFUSED;
                    end else if (i_managed == '0) begin
                        n_done   = 1'b1;
                        n_status = (ffua_pkg::t_op'(i_operation) == ffua_pkg::OP_ALLOC) ?
                                   ffua_pkg::ST_NO_FIT : ffua_pkg::ST_REFUSED;
                    end else begin
                        n_state = ffua_pkg::S_SCAN;
                    end
                end
            end
            ffua_pkg::S_SCAN: begin
                o_scan_cmd.valid = r_dv;
                o_we = r_dv && (r_op == ffua_pkg::OP_RELEASE) && i_scan_res.match;
                if (w_issue) begin
                    n_addr = r_addr + 1'b1;
                    n_dv   = 1'b1;
                    n_chk  = r_addr;
                end
                if (!w_issue && !r_dv) begin
                    n_state = ffua_pkg::S_IDLE;
                    n_done  = 1'b1;
                    case (r_op)
                        ffua_pkg::OP_ALLOC: begin
                            if (i_scan_res.hit) begin
                                n_status = ffua_pkg::ST_REFUSED;
                            end else if (i_scan_res.found) begin
                                n_state = ffua_pkg::S_FILL;
                                n_done  = 1'b0;
                                n_addr  = i_scan_start;
                                n_left  = i_block;
                            end else begin
                                n_status = ffua_pkg::ST_NO_FIT;
                            end
                        end
                        ffua_pkg::OP_RELEASE: begin
                            if (i_scan_cnt != '0) begin
                                n_free   = r_free + i_scan_cnt;
                                n_owners = r_owners - 1'b1;
                                n_status = ffua_pkg::ST_OK;
                            end else begin
                                n_status = ffua_pkg::ST_REFUSED;
                            end
                        end
                        ffua_pkg::OP_QUERY: begin
                            n_status = i_scan_res.hit ? ffua_pkg::ST_OK : ffua_pkg::ST_REFUSED;
                        end
                        default: begin
                            n_status = ffua_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ffua_pkg::S_FILL: begin
                o_we    = 1'b1;
                o_waddr = r_addr[AW-1:0];
                o_wdata = r_owner;
                n_addr  = r_addr + 1'b1;
                n_left  = r_left - 1'b1;
                if (r_left == ffua_pkg::CFG_W'(1)) begin
                    n_state      = ffua_pkg::S_IDLE;
                    n_done       = 1'b1;
                    n_status     = ffua_pkg::ST_OK;
                    n_start_unit = ffua_pkg::START_W'(i_scan_start);
                    n_free       = r_free - i_block;
                    n_owners     = r_owners + 1'b1;
                end
            end
            default: begin
                n_state = ffua_pkg::S_CLEAR;
                n_addr  = '0;
            end
        endcase

        if (i_reinit) begin
            n_state = ffua_pkg::S_CLEAR;
            n_addr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffua_pkg::S_CLEAR;
            r_addr   <= '0;
            r_dv     <= 1'b0;
            r_done   <= 1'b0;
            r_free   <= '0;
            r_owners <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_dv     <= n_dv;
            r_done   <= n_done;
            r_free   <= n_free;
            r_owners <= n_owners;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_chk        <= n_chk;
        r_owner      <= n_owner;
        r_left       <= n_left;
        r_status     <= n_status;
        r_start_unit <= n_start_unit;
    end

    assign busy              = (r_state != ffua_pkg::S_IDLE);
    assign o_owner           = r_owner;
    assign o_chk_idx         = r_chk;
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_start_unit      = r_start_unit;
    assign o_free_unit_count = r_free;
    assign o_resident_owners = r_owners;

endmodule

// ===== rtl/core/first_fit_unit_allocator_top.sv =====
// Operation 3, owner 0 and an empty managed range answer straight from idle; query, release
// and a refused allocate answer after one scan of the n managed units; a granted allocate then
// also writes its run of b units (b = run size).
// One command at a time: a new command is taken only while busy is low.
// Reset: synchronous, active low; a clearing pass over all MAP_DEPTH map words follows reset
// and every write of units_in_use, with busy held high. The receiver cannot stall.
//
// The owner map lives in a simple dual-port RAM with a registered read. The
// sequencer walks the map one unit per cycle, feeding each read word to a
// shared evaluator that tracks residency, the current free run, the first run
// that fits, and how many units match the owner. A release clears matching
// units on the write port during the same scan. A granted allocate is then
// written one unit per cycle. The free-unit and resident-owner counts are
// counters that update on the cycle the result word is produced.
module first_fit_unit_allocator_top #(
    parameter int MAP_DEPTH  = 1024,
    parameter int OWNER_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command handshake.
    input  logic                               start,
    output logic                               busy,
    input  logic [ffua_pkg::OP_W-1:0]          i_operation,
    input  logic [ffua_pkg::OWNER_W-1:0]       i_owner_id,
    // Result word, valid for one cycle while o_done is high.
    output logic                               o_done,
    output logic [ffua_pkg::STATUS_W-1:0]      o_status,
    output logic [ffua_pkg::START_W-1:0]       o_start_unit,
    output logic [ffua_pkg::CFG_W-1:0]         o_free_unit_count,
    output logic [ffua_pkg::CFG_W-1:0]         o_resident_owners,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ffua_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CW = AW + 1;

    logic [ffua_pkg::CFG_W-1:0] r_block_units;
    logic [ffua_pkg::CFG_W-1:0] r_units_in_use;

    logic                       w_cfg_wr;
    logic                       w_reinit;
    logic [ffua_pkg::CFG_W-1:0] w_block;
    logic [CW-1:0]              w_managed;

    ffua_pkg::t_scan_cmd        w_scan_cmd;
    ffua_pkg::t_scan_res        w_scan_res;
    logic [CW-1:0]              w_scan_start;
    logic [ffua_pkg::CFG_W-1:0] w_scan_cnt;
    logic [OWNER_BITS-1:0]      w_owner;
    logic [CW-1:0]              w_chk_idx;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [OWNER_BITS-1:0]      w_wdata;
    logic [AW-1:0]              w_raddr;
    logic [OWNER_BITS-1:0]      w_rdata;

    // Register writes complete in the access phase; pready is tied high.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reinit = w_cfg_wr && (paddr[2] == ffua_pkg::CFG_UNITS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_units  <= ffua_pkg::BLOCK_UNITS_RST;
            r_units_in_use <= ffua_pkg::UNITS_IN_USE_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == ffua_pkg::CFG_BLOCK_UNITS) begin
                r_block_units <= pwdata[ffua_pkg::CFG_W-1:0];
            end else begin
                r_units_in_use <= pwdata[ffua_pkg::CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ffua_pkg::CFG_BLOCK_UNITS) begin
            prdata = 32'(r_block_units);
        end else begin
            prdata = 32'(r_units_in_use);
        end
    end

    // A zero block size behaves as one unit; the managed range is capped at
    // the map depth.
    assign w_block   = (r_block_units == '0) ? ffua_pkg::CFG_W'(1) : r_block_units;
    assign w_managed = (32'(r_units_in_use) > 32'(MAP_DEPTH)) ?
                       CW'(MAP_DEPTH) : CW'(r_units_in_use);

    ffua_ram #(
        .DEPTH (MAP_DEPTH),
        .WIDTH (OWNER_BITS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ffua_scan #(
        .OWNER_BITS (OWNER_BITS),
        .CW         (CW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_scan_cmd),
        .i_owner (w_owner),
        .i_data  (w_rdata),
        .i_idx   (w_chk_idx),
        .i_block (w_block),
        .o_res   (w_scan_res),
        .o_start (w_scan_start),
        .o_cnt   (w_scan_cnt)
    );

    ffua_ctrl #(
        .MAP_DEPTH  (MAP_DEPTH),
        .OWNER_BITS (OWNER_BITS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_owner_id        (i_owner_id),
        .i_block           (w_block),
        .i_managed         (w_managed),
        .i_reinit          (w_reinit),
        .o_scan_cmd        (w_scan_cmd),
        .i_scan_res        (w_scan_res),
        .i_scan_start      (w_scan_start),
        .i_scan_cnt        (w_scan_cnt),
        .o_owner           (w_owner),
        .o_chk_idx         (w_chk_idx),
        .o_we              (w_we),
        .o_waddr           (w_waddr),
        .o_wdata           (w_wdata),
        .o_raddr           (w_raddr),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_start_unit      (o_start_unit),
        .o_free_unit_count (o_free_unit_count),
        .o_resident_owners (o_resident_owners)
    );

    // A result word only follows an accepted command or a busy cycle.
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(busy)))
        else $error("result word without a command in progress");

    // An accepted command either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !w_cfg_wr) |=> (busy || o_done))
        else $error("accepted command neither answered nor in progress");

    // While idle the free count never exceeds the managed range.
    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(w_reinit)) |-> (CW'(o_free_unit_count) <= w_managed))
        else $error("free unit count above managed units");

    // Any resident owner holds at least one unit.
    a_owner_holds_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(w_reinit) && (o_resident_owners != '0))
            |-> (CW'(o_free_unit_count) < w_managed))
        else $error("resident owner count without any used unit");

endmodule
